// File: src/sap_pkg.sv
package sap_pkg;

  localparam int unsigned SINE_TABLE_BITS  = 10;
  localparam int unsigned POWER_TABLE_BITS = 10;
  localparam int unsigned CHANNELS         = 2;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned COUNT_W  = 18;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned AMP_W    = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CHAN_W   = $clog2(CHANNELS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd2;

  localparam logic [COUNT_W-1:0] RATE_RESET = 18'd48000;
  localparam int unsigned        DEPTH_MAX  = 100;

  // One quarter of the sine cycle is stored, endpoints included.
  localparam int unsigned SINE_QTR      = 2 ** (SINE_TABLE_BITS - 2);
  localparam int unsigned SINE_QTR_LEN  = SINE_QTR + 1;
  localparam int unsigned SINE_QIDX_W   = SINE_TABLE_BITS - 1;
  localparam int unsigned SINE_HALF_DIV = 2 * SINE_QTR;
  localparam int unsigned SINE_MAG_W    = 15;

  localparam int unsigned POWER_SIZE  = 2 ** POWER_TABLE_BITS;
  localparam int unsigned POWER_LEN   = POWER_SIZE + 1;
  localparam int unsigned POWER_IDX_W = POWER_TABLE_BITS + 1;
  localparam int unsigned GAIN_W      = 17;
  localparam int unsigned MOD_W       = 17;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  audio;
    logic [CHAN_W-1:0]           side;
    logic [SINE_TABLE_BITS-1:0]  sidx;
  } sap_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINE,
    ST_MOD,
    ST_GAIN,
    ST_MUL,
    ST_OUT
  } sap_state_e;

  typedef logic [SINE_MAG_W-1:0] sine_qtr_tab_t [SINE_QTR_LEN];
  typedef logic [GAIN_W-1:0]     power_tab_t    [POWER_LEN];
  typedef logic [AMP_W-1:0]      amp_tab_t      [2 ** DEPTH_W];

  // sin(pi/2 * j / q) in Q1.15 by a Taylor series in Q30.
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(int unsigned j);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = (PI_Q30 * 64'(j)) / SINE_HALF_DIV;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - $signed(term);
    if (sum < 0) sum = 0;
    r = ($unsigned(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[SINE_MAG_W-1:0];
  endfunction

  function automatic sine_qtr_tab_t build_sine_qtr();
    sine_qtr_tab_t tab;
    for (int unsigned i = 0; i < SINE_QTR_LEN; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Entry k holds (k / POWER_SIZE)^0.75 with 16 fractional bits.
  function automatic power_tab_t build_power();
    power_tab_t  tab;
    logic [63:0] w;
    logic [63:0] s;
    logic [63:0] r;
    for (int unsigned i = 0; i < POWER_LEN; i++) begin
      w      = (64'(i) << (16 - POWER_TABLE_BITS)) << 16;
      s      = int_sqrt(w << 28);
      r      = int_sqrt(w * s);
      tab[i] = GAIN_W'((r + 64'd16384) >> 15);
    end
    return tab;
  endfunction

  // Sine amplitude in Q0.16 for each depth code; codes above the maximum clamp.
  function automatic amp_tab_t build_amp();
    amp_tab_t    tab;
    logic [31:0] d;
    for (int unsigned i = 0; i < 2 ** DEPTH_W; i++) begin
      d      = (i > DEPTH_MAX) ? 32'(DEPTH_MAX) : 32'(i);
      tab[i] = AMP_W'((d * 32'd65536 + 32'd100) / 200);
    end
    return tab;
  endfunction

  localparam sine_qtr_tab_t SINE_QTR_TAB = build_sine_qtr();
  localparam power_tab_t    POWER_TAB    = build_power();
  localparam amp_tab_t      AMP_TAB      = build_amp();

endpackage

// File: src/stereo_auto_pan.sv
// Stereo auto-panner with a sine LFO per channel. Each input beat carries one
// signed 24-bit sample and its channel (0 left, 1 right); each produces one
// output beat with the sample scaled by (1-mod)^0.75 on the left or mod^0.75
// on the right, rounded and saturated to 24 bits. The front end takes a beat
// every cycle into a four-entry queue while it is not full, and advances that
// channel's phase and sample count at once. The back end is a six-state
// sequencer (queue pop, sine lookup, modulation, gain lookup, multiply, round
// and output) that pops a new sample only once the last is in the output
// register, and it waits while the output is stalled. Configuration writes
// are to be made only while no sample is in flight; the block does not enforce
// this. They change only the register written; unused-index writes are dropped.
module stereo_auto_pan
  import sap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // [23:0] audio_in
  input  logic                 s_axis_tuser,   // [0] side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [23:0] audio_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [AMP_W-1:0]   amp_q;
  logic [PHASE_W-1:0] step_q;
  logic [COUNT_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q  <= '0;
      step_q <= '0;
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEPTH: amp_q  <= AMP_TAB[cfg_data_i[DEPTH_W-1:0]];
        REG_STEP:  step_q <= cfg_data_i[PHASE_W-1:0];
        REG_RATE:  rate_q <= cfg_data_i[COUNT_W-1:0];
        default:   amp_q  <= amp_q;
      endcase
    end
  end

  logic      push, full, pop, item_valid;
  sap_item_t push_item, pop_item;
  logic signed [SAMPLE_W-1:0] out_data;

  sap_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .audio_i      ($signed(s_axis_tdata)),
    .side_i       (s_axis_tuser),
    .phase_step_i (step_q),
    .rate_i       (rate_q),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  sap_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (item_valid),
    .item_o  (pop_item)
  );

  sap_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .amp_i        (amp_q),
    .item_valid_i (item_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data)
  );

  assign m_axis_tdata = out_data;

endmodule

// File: src/sap_front.sv
module sap_front
  import sap_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] audio_i,
  input  logic [CHAN_W-1:0]          side_i,
  input  logic [PHASE_W-1:0]         phase_step_i,
  input  logic [COUNT_W-1:0]         rate_i,
  input  logic                       full_i,
  output logic                       push_o,
  output sap_item_t                  item_o
);

  logic [PHASE_W-1:0] phase_q [CHANNELS];
  logic [COUNT_W-1:0] count_q [CHANNELS];

  logic [PHASE_W-1:0] phase_cur;
  logic [COUNT_W-1:0] count_cur;
  logic [COUNT_W:0]   count_inc;
  logic               wrap;
  logic [PHASE_W-1:0] phase_d;
  logic [COUNT_W-1:0] count_d;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign phase_cur = phase_q[side_i];
  assign count_cur = count_q[side_i];
  assign count_inc = {1'b0, count_cur} + {{COUNT_W{1'b0}}, 1'b1};
  assign wrap      = count_inc >= {1'b0, rate_i};

  // Once a second of samples has passed on this channel, phase and count restart.
  assign phase_d = wrap ? '0 : phase_cur + phase_step_i;
  assign count_d = wrap ? '0 : count_inc[COUNT_W-1:0];

  always_comb begin
    item_o.audio = audio_i;
    item_o.side  = side_i;
    item_o.sidx  = phase_cur[PHASE_W-1 -: SINE_TABLE_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_q[i] <= '0;
        count_q[i] <= '0;
      end
    end else if (push_o) begin
      phase_q[side_i] <= phase_d;
      count_q[side_i] <= count_d;
    end
  end

endmodule

// File: src/sap_queue.sv
module sap_queue
  import sap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sap_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output sap_item_t item_o
);

  sap_item_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   fill_q;
  logic                   do_push, do_pop;

  assign full_o  = fill_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign valid_o = fill_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

// File: src/sap_back.sv
module sap_back
  import sap_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [AMP_W-1:0]           amp_i,
  input  logic                       item_valid_i,
  input  sap_item_t                  item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SAMPLE_W-1:0] out_data_o
);

  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned RES_W    = PROD_W + 1 - 16;
  localparam int unsigned PIDX_W   = MOD_W + POWER_TABLE_BITS + 1;
  localparam int unsigned MODSUM_W = MOD_W + 3;

  sap_state_e state_q, state_d;

  sap_item_t                 item_q;
  logic signed [15:0]        sine_q;
  logic [MOD_W-1:0]          mod_q;
  logic [GAIN_W-1:0]         gain_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  logic load_item, load_sine, load_mod, load_gain, load_mul, load_out;

  // Sine lookup from the stored quarter wave.
  logic [1:0]              quad;
  logic [SINE_QIDX_W-1:0]  qidx;
  logic [SINE_MAG_W-1:0]   sine_mag;
  logic signed [15:0]      sine_val;

  assign quad = item_q.sidx[SINE_TABLE_BITS-1 -: 2];
  assign qidx = quad[0]
              ? SINE_QIDX_W'(SINE_QTR) - {1'b0, item_q.sidx[SINE_TABLE_BITS-3:0]}
              : {1'b0, item_q.sidx[SINE_TABLE_BITS-3:0]};
  assign sine_mag = SINE_QTR_TAB[qidx];
  assign sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

  // mod = 1 - 2a + a * (sine + 1), with the sine offset to unsigned.
  logic [31:0]                 amp_prod;
  logic [32:0]                 amp_rnd;
  logic signed [MODSUM_W-1:0]  mod_sum;
  logic [MOD_W-1:0]            mod_val;

  assign amp_prod = {16'd0, amp_i} * {16'd0, sine_q ^ 16'sh8000};
  assign amp_rnd  = {1'b0, amp_prod} + 33'd16384;
  assign mod_sum  = $signed(MODSUM_W'(65536)) - $signed(MODSUM_W'({amp_i, 1'b0}))
                  + $signed(MODSUM_W'(amp_rnd[32:15]));

  always_comb begin
    if (mod_sum < 0) begin
      mod_val = '0;
    end else if (mod_sum > $signed(MODSUM_W'(65536))) begin
      mod_val = MOD_W'(65536);
    end else begin
      mod_val = mod_sum[MOD_W-1:0];
    end
  end

  // Power table index from the channel's share of the swing.
  logic [MOD_W-1:0]       share;
  logic [PIDX_W-1:0]      pidx_sum;
  logic [PIDX_W-17:0]     pidx_raw;
  logic [POWER_IDX_W-1:0] pidx;

  assign share    = (item_q.side == '0) ? MOD_W'(65536) - mod_q : mod_q;
  assign pidx_sum = (PIDX_W'(share) << POWER_TABLE_BITS) + PIDX_W'(32768);
  assign pidx_raw = pidx_sum[PIDX_W-1:16];
  assign pidx     = (pidx_raw > (PIDX_W - 16)'(POWER_SIZE))
                  ? POWER_IDX_W'(POWER_SIZE) : pidx_raw[POWER_IDX_W-1:0];

  // Round to nearest with ties upward, then saturate.
  logic signed [PROD_W:0]    prod_rnd;
  logic signed [RES_W-1:0]   res;
  logic signed [SAMPLE_W-1:0] res_sat;

  assign prod_rnd = {prod_q[PROD_W-1], prod_q} + (PROD_W + 1)'(32768);
  assign res      = prod_rnd[PROD_W:16];

  always_comb begin
    if (res > $signed(RES_W'(8388607))) begin
      res_sat = 24'sh7FFFFF;
    end else if (res < -$signed(RES_W'(8388608))) begin
      res_sat = 24'sh800000;
    end else begin
      res_sat = res[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (item_valid_i) state_d = ST_SINE;
      ST_SINE: state_d = ST_MOD;
      ST_MOD:  state_d = ST_GAIN;
      ST_GAIN: state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    load_item = 1'b0;
    load_sine = 1'b0;
    load_mod  = 1'b0;
    load_gain = 1'b0;
    load_mul  = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: load_item = item_valid_i;
      ST_SINE: load_sine = 1'b1;
      ST_MOD:  load_mod  = 1'b1;
      ST_GAIN: load_gain = 1'b1;
      ST_MUL:  load_mul  = 1'b1;
      ST_OUT:  load_out  = !out_valid_q || out_ready_i;
      default: load_item = 1'b0;
    endcase
  end

  assign pop_o = load_item;

  always_ff @(posedge clk_i) begin
    if (load_item) item_q <= item_i;
    if (load_sine) sine_q <= sine_val;
    if (load_mod)  mod_q  <= mod_val;
    if (load_gain) gain_q <= POWER_TAB[pidx];
    if (load_mul)  prod_q <= item_q.audio * $signed({1'b0, gain_q});
    if (load_out)  out_data_q <= res_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: tb/sv/pan_gain_checker.sv
module pan_gain_checker
  import sap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [23:0]          s_tdata_i,   // [23:0] audio_in
  input  logic                 s_tuser_i,   // [0] side
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [23:0]          m_tdata_i,   // [23:0] audio_out
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SINE_LEN  = 2 ** SINE_TABLE_BITS;
  localparam int unsigned GAIN_LEN  = 2 ** POWER_TABLE_BITS + 1;
  localparam longint      UNITY     = 65536;
  localparam longint      PI_FIXED  = 64'd3373259426;  // pi in Q30

  longint sine_lut [SINE_LEN];
  longint gain_lut [GAIN_LEN];

  logic [DEPTH_W-1:0]         depth_reg;
  logic [PHASE_W-1:0]         step_reg;
  logic [COUNT_W-1:0]         rate_reg;
  logic [PHASE_W-1:0]         phase_q [CHANNELS];
  logic [COUNT_W-1:0]         count_q [CHANNELS];
  logic signed [SAMPLE_W-1:0] pending_audio [$];

  // Quarter-wave sine in Q1.15 from a Taylor series carried in Q30.
  function automatic longint quarter_wave(longint unsigned j, longint unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    x    = (PI_FIXED * j) / (2 * q);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) + 16384) >> 15;
    return (r > 32767) ? 32767 : longint'(r);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  initial begin
    longint unsigned q;
    longint unsigned w;
    longint unsigned s;
    longint          mag;
    q = SINE_LEN / 4;
    for (int unsigned i = 0; i < SINE_LEN; i++) begin
      mag = ((i / q) % 2 == 1) ? quarter_wave(q - i % q, q) : quarter_wave(i % q, q);
      sine_lut[i] = ((i / q) >= 2) ? -mag : mag;
    end
    // Gain entry k is (k / size)^0.75, taken as the root of k times its own root.
    for (int unsigned i = 0; i < GAIN_LEN; i++) begin
      w = longint'(i) << (32 - POWER_TABLE_BITS);
      s = floor_root(w << 28);
      gain_lut[i] = longint'((floor_root(w * s) + 16384) >> 15);
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pan_sample(
    logic signed [SAMPLE_W-1:0] audio,
    logic                       side
  );
    longint depth;
    longint amp;
    longint lfo;
    longint mod;
    longint level;
    longint idx;
    longint res;
    depth = (depth_reg > DEPTH_MAX) ? longint'(DEPTH_MAX) : longint'(depth_reg);
    amp   = (depth * UNITY + 100) / 200;
    lfo   = sine_lut[phase_q[side] >> (PHASE_W - SINE_TABLE_BITS)];
    mod   = UNITY - 2 * amp + ((amp * (lfo + 32768) + 16384) >>> 15);
    if (mod < 0) mod = 0;
    if (mod > UNITY) mod = UNITY;
    level = side ? mod : UNITY - mod;
    idx   = (level * (2 ** POWER_TABLE_BITS) + 32768) >>> 16;
    if (idx > GAIN_LEN - 1) idx = GAIN_LEN - 1;
    res = (longint'(audio) * gain_lut[idx] + 32768) >>> 16;
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    return res[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [SAMPLE_W-1:0] want;
    logic                       ch;
    if (!rst_ni) begin
      depth_reg = '0;
      step_reg  = '0;
      rate_reg  = RATE_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
        phase_q[c] = '0;
        count_q[c] = '0;
      end
      pending_audio.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEPTH: depth_reg = cfg_data_i[DEPTH_W-1:0];
          REG_STEP:  step_reg  = cfg_data_i[PHASE_W-1:0];
          REG_RATE:  rate_reg  = cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        ch = s_tuser_i;
        pending_audio.push_back(pan_sample($signed(s_tdata_i), ch));
        phase_q[ch] = phase_q[ch] + step_reg;
        // A full second of samples restarts the channel, also when the
        // rate was lowered below the running count.
        if (32'(count_q[ch]) + 32'd1 >= 32'(rate_reg)) begin
          count_q[ch] = '0;
          phase_q[ch] = '0;
        end else begin
          count_q[ch] = count_q[ch] + 1'b1;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pending_audio.size() == 0) begin
          errors_o++;
          $error("audio_out beat with no sample pending: actual %0d", $signed(m_tdata_i));
        end else begin
          want = pending_audio.pop_front();
          if (m_tdata_i !== want) begin
            errors_o++;
            $error("audio_out mismatch: expected %0d, actual %0d", want, $signed(m_tdata_i));
          end
        end
      end
      pending_o = pending_audio.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sap_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned          IDLE_LIMIT = 1000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;   // [23:0] audio_in
  logic                 s_axis_tuser;   // [0] side
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [23:0]          m_axis_tdata;   // [23:0] audio_out
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int          mismatch_count;
  int          audio_in_flight;
  int unsigned idle_cycles;
  bit          src_burst;
  bit          sink_burst;

  stereo_auto_pan i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  pan_gain_checker i_checker (
    .clk_i,
    .rst_ni,
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .errors_o   (mismatch_count),
    .pending_o  (audio_in_flight)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: unless in burst mode, stall a random number of cycles before each beat.
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back beats; it drops only for a gap or a drain.
  task automatic send_sample(input logic [23:0] audio, input logic side);
    int unsigned gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= audio;
    s_axis_tuser  <= side;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (audio_in_flight != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [23:0] audio;
    logic        side;
    bit          stereo;
    int unsigned pick;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    side       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero depth after reset: the right side passes through, the left is muted.
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'h800000, 1'b1);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'h000001, 1'b0);
    drain();

    // Full depth with a quarter-cycle step walks through the sine extremes.
    write_reg(REG_DEPTH, 32'd100);
    write_reg(REG_STEP, 32'h4000_0000);
    write_reg(REG_RATE, 32'd8000);
    for (int k = 0; k < 4; k++) begin
      send_sample((k % 2 == 1) ? 24'h800000 : 24'h7FFFFF, 1'b1);
      send_sample(24'h800000, 1'b0);
    end
    drain();

    // Depth above the maximum, a wrapping step, and a zero rate.
    write_reg(REG_DEPTH, 32'd127);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    write_reg(REG_RATE, 32'd0);
    send_sample(24'h555555, 1'b0);
    send_sample(24'hAAAAAA, 1'b1);
    drain();
    write_reg(REG_RATE, 32'd1);
    send_sample(24'h123456, 1'b1);
    send_sample(24'hEDCBA9, 1'b1);
    drain();
    write_reg(REG_STEP, 32'h8000_0000);
    write_reg(REG_RATE, 32'd3);
    for (int k = 0; k < 4; k++) send_sample(24'h400000 + 24'(k), 1'b0);
    drain();

    // Unused index is dropped; bits above the depth field are ignored.
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_DEPTH, 32'hFFFF_FF85);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);

    for (int p = 0; p < 14; p++) begin
      drain();
      src_burst  = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      stereo     = ($urandom_range(0, 3) != 0);
      if (p == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       pick = 0;
          1:       pick = DEPTH_MAX;
          2:       pick = 127;
          default: pick = $urandom_range(0, 127);
        endcase
        write_reg(REG_DEPTH, ($urandom_range(0, 1) ? ($urandom() << DEPTH_W) : 32'd0) | pick);
      end
      if (p == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0:       pick = 0;
          1:       pick = 32'hFFFF_FFFF;
          2:       pick = $urandom_range(0, 65535);
          default: pick = $urandom();
        endcase
        write_reg(REG_STEP, pick);
      end
      if (p == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 7))
          0:       pick = 0;
          1:       pick = 1;
          2:       pick = 192000;
          3:       pick = 262143;
          4:       pick = 8000;
          default: pick = $urandom_range(2, 400);
        endcase
        write_reg(REG_RATE, ($urandom_range(0, 1) ? ($urandom() << COUNT_W) : 32'd0) | pick);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());

      for (int n = 0; n < 120; n++) begin
        case ($urandom_range(0, 7))
          0:       audio = 24'h7FFFFF;
          1:       audio = 24'h800000;
          2:       audio = 24'($urandom_range(0, 511)) - 24'd256;
          default: audio = 24'($urandom());
        endcase
        side = stereo ? ~side : 1'($urandom_range(0, 1));
        send_sample(audio, side);
      end
    end
    drain();

    if (mismatch_count == 0 && audio_in_flight == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/sap_pkg.sv
src/sap_front.sv
src/sap_queue.sv
src/sap_back.sv
src/stereo_auto_pan.sv
tb/sv/pan_gain_checker.sv
tb/sv/testbench.sv
